// ===== sv/sacc_pkg.sv =====
// Shared types and constants for the set-associative hit counter.
// No dependencies; used by every module of the block.
package sacc_pkg;

  localparam int TOTAL_BLOCKS      = 8;
  localparam int WAY_W             = 3;
  localparam int SET_W             = 3;
  localparam int ADDR_W            = 8;
  localparam int WAYS_LOG2_W       = 2;
  localparam int COUNT_W           = 8;
  localparam int TOTAL_W           = 16;
  localparam int ADDR_BITS_DEFAULT = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [SET_W-1:0]   SET_MASK_FULL = '1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // One classified beat waiting for the back end.
  typedef struct packed {
    logic                   cmd;
    logic [WAYS_LOG2_W-1:0] ways_log2;
    logic [SET_W-1:0]       set_index;
    logic [ADDR_W-1:0]      addr;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic [SET_W-1:0]   set_index;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } result_t;

endpackage

// ===== sv/sacc_front.sv =====
// Front end: holds the associativity register, accepts input beats and
// tags each with its set and arrangement. Depends on sacc_pkg.
module sacc_front #(
  parameter int ADDR_BITS = sacc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [sacc_pkg::WAYS_LOG2_W-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [sacc_pkg::ADDR_W-1:0]          block_address,
  output logic                                 push,
  output sacc_pkg::entry_t                     push_entry,
  input  logic                                 queue_full
);

  localparam int TAG_W = (ADDR_BITS < sacc_pkg::ADDR_W) ? ADDR_BITS : sacc_pkg::ADDR_W;

  logic [sacc_pkg::WAYS_LOG2_W-1:0] ways_log2;
  logic [sacc_pkg::ADDR_W-1:0]      addr_masked;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2 <= '0;
    end else if (cfg_wr_en) begin
      ways_log2 <= cfg_wr_data;
    end
  end

  assign in_ready    = !queue_full;
  assign push        = in_valid && in_ready;
  assign addr_masked = sacc_pkg::ADDR_W'(block_address[TAG_W-1:0]);

  always_comb begin
    push_entry.cmd       = cmd;
    push_entry.ways_log2 = ways_log2;
    push_entry.addr      = addr_masked;
    // set count is 8 >> ways_log2, so the set is the low address bits masked
    push_entry.set_index = addr_masked[sacc_pkg::SET_W-1:0]
                           & (sacc_pkg::SET_MASK_FULL >> ways_log2);
  end

endmodule

// ===== sv/sacc_queue.sv =====
// Short FIFO of classified beats between front and back ends.
// Depends on sacc_pkg for the entry type and depth.
module sacc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sacc_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sacc_pkg::entry_t head_entry
);

  localparam int DEPTH = sacc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sacc_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== sv/sacc_back.sv =====
// Back end: tag, valid and use-count state, hit lookup, victim choice,
// totals and the output register. Depends on sacc_pkg.
module sacc_back #(
  parameter int ADDR_BITS = sacc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sacc_pkg::entry_t  head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output sacc_pkg::result_t result
);

  localparam int NB      = sacc_pkg::TOTAL_BLOCKS;
  localparam int TAG_W   = (ADDR_BITS < sacc_pkg::ADDR_W) ? ADDR_BITS : sacc_pkg::ADDR_W;
  localparam int KEY_W   = sacc_pkg::COUNT_W + 1;
  localparam int WAY_W   = sacc_pkg::WAY_W;
  localparam int SET_W   = sacc_pkg::SET_W;
  localparam int COUNT_W = sacc_pkg::COUNT_W;
  localparam int TOTAL_W = sacc_pkg::TOTAL_W;

  logic [TAG_W-1:0]   tag_store [NB];
  logic [NB-1:0]      valid_bits;
  logic [COUNT_W-1:0] use_count [NB];
  logic [TOTAL_W-1:0] hits_so_far;
  logic [TOTAL_W-1:0] misses_so_far;

  logic [TAG_W-1:0]   addr;
  logic [WAY_W-1:0]   way_mask;
  logic [NB-1:0]      member;
  logic [NB-1:0]      match;
  logic               found;
  logic [WAY_W-1:0]   hit_block;

  logic [KEY_W-1:0]   key_l0 [8];
  logic [WAY_W-1:0]   idx_l0 [8];
  logic [KEY_W-1:0]   key_l1 [4];
  logic [WAY_W-1:0]   idx_l1 [4];
  logic [KEY_W-1:0]   key_l2 [2];
  logic [WAY_W-1:0]   idx_l2 [2];
  logic [WAY_W-1:0]   victim;
  logic [WAY_W-1:0]   chosen_block;

  logic [TOTAL_W-1:0] hits_next;
  logic [TOTAL_W-1:0] misses_next;

  assign pop  = head_valid && (!out_valid || out_ready);
  assign addr = head_entry.addr[TAG_W-1:0];
  assign way_mask = WAY_W'((4'd1 << head_entry.ways_log2) - 4'd1);

  // block b sits in set b >> k at way b & (ways - 1)
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      member[b] = ((WAY_W'(b) >> head_entry.ways_log2) == head_entry.set_index);
      match[b]  = member[b] && valid_bits[b] && (tag_store[b] == addr);
    end
  end

  // lowest matching block is the lowest matching way
  always_comb begin
    found     = 1'b0;
    hit_block = '0;
    for (int b = NB - 1; b >= 0; b--) begin
      if (match[b]) begin
        found     = 1'b1;
        hit_block = WAY_W'(b);
      end
    end
  end

  // min tree over use counts; blocks outside the set get a key above any count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_l0[i] = {!member[i], use_count[i]};
      idx_l0[i] = WAY_W'(i);
    end
    for (int i = 0; i < 4; i++) begin
      if (key_l0[2*i] <= key_l0[2*i+1]) begin
        key_l1[i] = key_l0[2*i];
        idx_l1[i] = idx_l0[2*i];
      end else begin
        key_l1[i] = key_l0[2*i+1];
        idx_l1[i] = idx_l0[2*i+1];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (key_l1[2*i] <= key_l1[2*i+1]) begin
        key_l2[i] = key_l1[2*i];
        idx_l2[i] = idx_l1[2*i];
      end else begin
        key_l2[i] = key_l1[2*i+1];
        idx_l2[i] = idx_l1[2*i+1];
      end
    end
    victim = (key_l2[0] <= key_l2[1]) ? idx_l2[0] : idx_l2[1];
  end

  assign chosen_block = found ? hit_block : victim;

  always_comb begin
    hits_next   = hits_so_far;
    misses_next = misses_so_far;
    if (head_entry.cmd == sacc_pkg::CMD_CLEAR) begin
      hits_next   = '0;
      misses_next = '0;
    end else if (found) begin
      if (hits_so_far != sacc_pkg::TOTAL_MAX) begin
        hits_next = hits_so_far + 1'b1;
      end
    end else begin
      if (misses_so_far != sacc_pkg::TOTAL_MAX) begin
        misses_next = misses_so_far + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits    <= '0;
      hits_so_far   <= '0;
      misses_so_far <= '0;
      out_valid     <= 1'b0;
      for (int b = 0; b < NB; b++) begin
        use_count[b] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !pop) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        out_valid     <= 1'b1;
        hits_so_far   <= hits_next;
        misses_so_far <= misses_next;
        if (head_entry.cmd == sacc_pkg::CMD_CLEAR) begin
          valid_bits <= '0;
          for (int b = 0; b < NB; b++) begin
            use_count[b] <= '0;
          end
        end else if (found) begin
          if (use_count[hit_block] != sacc_pkg::COUNT_MAX) begin
            use_count[hit_block] <= use_count[hit_block] + 1'b1;
          end
        end else begin
          valid_bits[victim] <= 1'b1;
          use_count[victim]  <= '0;
        end
      end
    end
  end

  // payload: tags and the output beat carry no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_entry.cmd == sacc_pkg::CMD_CLEAR) begin
        result.hit       <= 1'b0;
        result.way       <= '0;
        result.set_index <= '0;
      end else begin
        if (!found) begin
          tag_store[victim] <= addr;
        end
        result.hit       <= found;
        result.way       <= chosen_block & way_mask;
        result.set_index <= head_entry.set_index;
      end
      result.hit_total  <= hits_next;
      result.miss_total <= misses_next;
    end
  end

endmodule

// ===== sv/set_assoc_cache_hit_counter_unit.sv =====
// Set-associative cache model with least-frequently-used replacement and
// saturating hit and miss totals. Top level; depends on sacc_pkg and the
// sacc_front, sacc_queue and sacc_back modules.
//
// Usage:
//   Input beats (cmd, block_address) are taken on in_valid && in_ready. An
//   access looks the address up in its set; a clear empties the cache and
//   resets the totals. Each input beat gives exactly one output beat (hit,
//   way, set_index, hit_total, miss_total) on out_valid && out_ready.
//   The associativity register is written with cfg_wr_en / cfg_wr_data
//   while the block is idle; stored blocks are kept across a change.
//   Throughput is one beat per cycle while out_ready stays high: the front end
//   classifies a beat into a two-entry queue, and the back end does the tag
//   compare, the min tree victim pick and the state update together.
//   An accepted beat is written into the queue; the back end pops it from the
//   head into the output register, where out_valid rises. When the
//   receiver stalls the output register holds its beat, the queue fills,
//   and in_ready drops once both entries are occupied.
//   Reset (rst, synchronous) clears all valid bits, use counts, totals and
//   the register (direct mapped); the block accepts beats right after.
module set_assoc_cache_hit_counter_unit #(
  parameter int ADDR_BITS = sacc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [sacc_pkg::WAYS_LOG2_W-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [sacc_pkg::ADDR_W-1:0]          block_address,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic [sacc_pkg::WAY_W-1:0]           way,
  output logic [sacc_pkg::SET_W-1:0]           set_index,
  output logic [sacc_pkg::TOTAL_W-1:0]         hit_total,
  output logic [sacc_pkg::TOTAL_W-1:0]         miss_total
);

  logic              push;
  sacc_pkg::entry_t  push_entry;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  sacc_pkg::entry_t  head_entry;
  sacc_pkg::result_t result;

  sacc_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .block_address (block_address),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (queue_full)
  );

  sacc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  sacc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign hit        = result.hit;
  assign way        = result.way;
  assign set_index  = result.set_index;
  assign hit_total  = result.hit_total;
  assign miss_total = result.miss_total;

endmodule

// ===== sim/sacc_lookup_checker.sv =====
// Lookup checker for the set-associative hit counter: keeps its own copy of
// tags, valid bits, use counts, totals and the associativity register.
// Depends on sacc_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps
module sacc_lookup_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sacc_pkg::WAYS_LOG2_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             cmd,
  input  logic [sacc_pkg::ADDR_W-1:0]      block_address,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             hit,
  input  logic [sacc_pkg::WAY_W-1:0]       way,
  input  logic [sacc_pkg::SET_W-1:0]       set_index,
  input  logic [sacc_pkg::TOTAL_W-1:0]     hit_total,
  input  logic [sacc_pkg::TOTAL_W-1:0]     miss_total,
  output int                               fail_count,
  output int                               pending
);

  localparam int NB      = sacc_pkg::TOTAL_BLOCKS;
  localparam int TOTAL_W = sacc_pkg::TOTAL_W;

  logic [sacc_pkg::ADDR_W-1:0]      tag_mem    [NB];
  bit                               line_valid [NB];
  logic [sacc_pkg::COUNT_W-1:0]     lfu_count  [NB];
  logic [TOTAL_W-1:0]               hit_tally;
  logic [TOTAL_W-1:0]               miss_tally;
  logic [sacc_pkg::WAYS_LOG2_W-1:0] ways_sel;
  sacc_pkg::result_t                lookup_results_q[$];
  sacc_pkg::result_t                want;

  task automatic report_mismatch(input string msg);
    $display("%0t: lookup mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                             input logic [TOTAL_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  task automatic empty_lines();
    for (int b = 0; b < NB; b++) begin
      tag_mem[b]    = '0;
      line_valid[b] = 1'b0;
      lfu_count[b]  = '0;
    end
    hit_tally  = '0;
    miss_tally = '0;
  endtask

  // One beat through the cache; returns the result it should produce.
  task automatic predict_lookup(input logic c, input logic [sacc_pkg::ADDR_W-1:0] addr,
                                output sacc_pkg::result_t r);
    int  nways;
    int  nsets;
    int  setn;
    int  base;
    int  best;
    int  pick;
    bit  found;
    r = '0;
    if (c == sacc_pkg::CMD_CLEAR) begin
      empty_lines();
      return;
    end
    nways = 1 << ways_sel;
    if (nways > NB) nways = NB;
    nsets = NB / nways;
    setn  = int'(addr) % nsets;
    base  = setn * nways;
    found = 1'b0;
    pick  = 0;
    // lowest valid matching way wins when duplicates exist
    for (int w = 0; w < nways; w++) begin
      if (!found && line_valid[base + w] && tag_mem[base + w] == addr) begin
        found = 1'b1;
        pick  = w;
      end
    end
    if (found) begin
      if (lfu_count[base + pick] != sacc_pkg::COUNT_MAX) lfu_count[base + pick]++;
      if (hit_tally != sacc_pkg::TOTAL_MAX) hit_tally++;
    end else begin
      // smallest use count, lowest way on ties; valid bit plays no part
      best = 1 << sacc_pkg::COUNT_W;
      for (int w = 0; w < nways; w++) begin
        if (int'(lfu_count[base + w]) < best) begin
          best = int'(lfu_count[base + w]);
          pick = w;
        end
      end
      tag_mem[base + pick]    = addr;
      line_valid[base + pick] = 1'b1;
      lfu_count[base + pick]  = '0;
      if (miss_tally != sacc_pkg::TOTAL_MAX) miss_tally++;
    end
    r.hit        = found;
    r.way        = pick[sacc_pkg::WAY_W-1:0];
    r.set_index  = setn[sacc_pkg::SET_W-1:0];
    r.hit_total  = hit_tally;
    r.miss_total = miss_tally;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ways_sel = '0;
      empty_lines();
      lookup_results_q.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_results_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = lookup_results_q.pop_front();
          check_field("hit", TOTAL_W'(hit), TOTAL_W'(want.hit));
          check_field("way", TOTAL_W'(way), TOTAL_W'(want.way));
          check_field("set_index", TOTAL_W'(set_index), TOTAL_W'(want.set_index));
          check_field("hit_total", hit_total, want.hit_total);
          check_field("miss_total", miss_total, want.miss_total);
        end
      end
      // a beat taken at the write edge still sees the old register
      if (in_valid && in_ready) begin
        predict_lookup(cmd, block_address, want);
        lookup_results_q.push_back(want);
      end
      if (cfg_wr_en) ways_sel = cfg_wr_data;
      pending = lookup_results_q.size();
    end
  end

endmodule

// ===== sim/set_assoc_cache_hit_counter_unit_tb.sv =====
// Testbench top for set_assoc_cache_hit_counter_unit: drives beats and the
// associativity register, stalls the output, and gives the verdict.
// Depends on sacc_pkg, the block, and sacc_lookup_checker.
`timescale 1ns / 1ps
module set_assoc_cache_hit_counter_unit_tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int POOL_MAX    = 12;
  localparam int AW          = sacc_pkg::ADDR_W;
  localparam int WLW         = sacc_pkg::WAYS_LOG2_W;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [WLW-1:0]                 cfg_wr_data;
  logic                           in_valid;
  logic                           in_ready;
  logic                           cmd;
  logic [AW-1:0]                  block_address;
  logic                           out_valid;
  logic                           out_ready;
  logic                           hit;
  logic [sacc_pkg::WAY_W-1:0]     way;
  logic [sacc_pkg::SET_W-1:0]     set_index;
  logic [sacc_pkg::TOTAL_W-1:0]   hit_total;
  logic [sacc_pkg::TOTAL_W-1:0]   miss_total;

  int  fail_count;
  int  pending_beats;
  int  burst_left;
  int  beats_sent;
  int  clears_sent;
  int  settings_done;
  int  out_beats;
  int  hits_seen;
  int  idle_cycles;
  int  holds_done;
  bit  steady;
  bit  hold_req;

  logic [AW-1:0] addr_pool [POOL_MAX];
  int            pool_size;

  set_assoc_cache_hit_counter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .block_address (block_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .way           (way),
    .set_index     (set_index),
    .hit_total     (hit_total),
    .miss_total    (miss_total)
  );

  sacc_lookup_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .block_address (block_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .way           (way),
    .set_index     (set_index),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .fail_count    (fail_count),
    .pending       (pending_beats)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one beat and hold it until taken; gaps fall between bursts.
  task automatic send_item(input logic c, input logic [AW-1:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    cmd           <= c;
    block_address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (c == sacc_pkg::CMD_CLEAR) clears_sent++;
  endtask

  // Stop offering and wait for every outstanding result beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_ways(input logic [WLW-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_done++;
  endtask

  // Receiver: stretches of always-ready, random, mostly-stalled and periodic.
  initial begin
    int mode;
    int span;
    int tick;
    out_ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_done++;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (tick % 3 != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        out_beats++;
        if (hit) hits_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                   IDLE_LIMIT, pending_beats);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int             r;
    logic [WLW-1:0] choice;
    logic [AW-1:0]  hot_addr;
    steady        = 1'b0;
    hold_req      = 1'b0;
    burst_left    = 0;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    cmd           <= sacc_pkg::CMD_ACCESS;
    block_address <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // direct mapped out of reset: address 0 must miss in an empty cache
    send_item(sacc_pkg::CMD_ACCESS, 8'h00);
    send_item(sacc_pkg::CMD_ACCESS, 8'h00);
    send_item(sacc_pkg::CMD_ACCESS, 8'h08);
    send_item(sacc_pkg::CMD_ACCESS, 8'h80);
    send_item(sacc_pkg::CMD_ACCESS, 8'hFF);
    send_item(sacc_pkg::CMD_ACCESS, 8'hFF);
    send_item(sacc_pkg::CMD_ACCESS, 8'h07);
    send_item(sacc_pkg::CMD_CLEAR,  8'hA5);
    send_item(sacc_pkg::CMD_ACCESS, 8'h03);
    // fully associative, old blocks kept and reread in place
    write_ways(2'd3);
    send_item(sacc_pkg::CMD_ACCESS, 8'h03);
    send_item(sacc_pkg::CMD_ACCESS, 8'h55);
    send_item(sacc_pkg::CMD_ACCESS, 8'hAA);
    send_item(sacc_pkg::CMD_ACCESS, 8'h55);
    send_item(sacc_pkg::CMD_ACCESS, 8'h0F);
    send_item(sacc_pkg::CMD_CLEAR,  8'h00);
    send_item(sacc_pkg::CMD_ACCESS, 8'h03);
    // park a second copy of 0x03 in block 3, evict it with 0x0B, then look 0x03 up fully assoc
    write_ways(2'd0);
    send_item(sacc_pkg::CMD_ACCESS, 8'h03);
    send_item(sacc_pkg::CMD_ACCESS, 8'h0B);
    write_ways(2'd3);
    send_item(sacc_pkg::CMD_ACCESS, 8'h03);
    write_ways(2'd1);
    send_item(sacc_pkg::CMD_ACCESS, 8'h01);
    send_item(sacc_pkg::CMD_ACCESS, 8'h41);
    send_item(sacc_pkg::CMD_ACCESS, 8'h81);
    send_item(sacc_pkg::CMD_ACCESS, 8'h41);
    write_ways(2'd2);
    send_item(sacc_pkg::CMD_ACCESS, 8'hFE);
    send_item(sacc_pkg::CMD_ACCESS, 8'h02);

    // hot address long enough to pin its use count; long receiver hold here
    write_ways(2'd3);
    send_item(sacc_pkg::CMD_CLEAR, 8'h00);
    hot_addr = AW'($urandom_range(0, 255));
    for (int i = 0; i < 6; i++) addr_pool[i] = AW'($urandom_range(0, 255));
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (330) begin
      if ($urandom_range(0, 9) != 0) send_item(sacc_pkg::CMD_ACCESS, hot_addr);
      else send_item(sacc_pkg::CMD_ACCESS, addr_pool[$urandom_range(0, 5)]);
    end
    steady = 1'b0;

    // small address pools make hits, conflicts and duplicate tags likely
    for (int p = 0; p < 11; p++) begin
      choice = (p < 4) ? (2'(p) ^ (2'(p) >> 1)) : 2'($urandom_range(0, 3));
      write_ways(choice);
      pool_size = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < pool_size; i++) addr_pool[i] = AW'($urandom_range(0, 255));
      steady = ($urandom_range(0, 3) == 0);
      repeat (75) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_item(sacc_pkg::CMD_CLEAR, AW'($urandom_range(0, 255)));
        else if (r < 12) send_item(sacc_pkg::CMD_ACCESS, AW'($urandom_range(0, 255)));
        else send_item(sacc_pkg::CMD_ACCESS, addr_pool[$urandom_range(0, pool_size - 1)]);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d beats (%0d clears) over %0d register writes.",
             beats_sent, clears_sent, settings_done);
    $display("Results checked: %0d, of which %0d hits; long output holds: %0d.",
             out_beats, hits_seen, holds_done);
    if (fail_count == 0 && pending_beats == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sacc_pkg.sv
sv/sacc_front.sv
sv/sacc_queue.sv
sv/sacc_back.sv
sv/set_assoc_cache_hit_counter_unit.sv
sim/sacc_lookup_checker.sv
sim/set_assoc_cache_hit_counter_unit_tb.sv
